/* rtl/ancc_pkg.sv */
package ancc_pkg;

   localparam int FRAC_W     = 12;
   localparam int NUM_STYLES = 6;
   localparam int NUM_FEAT   = 10;
   localparam int NUM_ELEM   = NUM_STYLES * NUM_FEAT;
   localparam int ADDR_W     = $clog2(NUM_ELEM);

   typedef logic [FRAC_W-1:0] frac_type;

   localparam frac_type ONE = frac_type'((1 << FRAC_W) - 1);

   // Reciprocals for division by constants: floor(2^K / D).
   localparam logic [31:0] RECIP_10_SMALL = 32'd104857;     // K = 20
   localparam logic [31:0] RECIP_10_WIDE  = 32'd429496729;  // K = 32
   localparam logic [31:0] RECIP_100      = 32'd2684354;    // K = 28
   localparam logic [31:0] RECIP_1000     = 32'd268435;     // K = 28
   localparam logic [31:0] RECIP_1120     = 32'd3834792;    // K = 32
   localparam logic [31:0] RECIP_ONE      = 32'd1048832;    // K = 32

   typedef enum logic [1:0] {
      MODE_CLASSIFY = 2'd0,
      MODE_LEARN    = 2'd1,
      MODE_RESTORE  = 2'd2,
      MODE_UNUSED   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CSR_SILENCE_RMS  = 2'd0,
      CSR_SILENCE_PEAK = 2'd1,
      CSR_LEARN_CONF   = 2'd2,
      CSR_LEARN_RMS    = 2'd3
   } csr_type;

   // Default style centroids, row by row, hundredths scaled to full scale.
   localparam frac_type DEFAULT_CENTROID [NUM_ELEM] = '{
      12'd0,    12'd0,    12'd0,    12'd0,    12'd0,
      12'd0,    12'd0,    12'd0,    12'd0,    12'd0,
      12'd532,  12'd655,  12'd983,  12'd1310, 12'd983,
      12'd901,  12'd1147, 12'd1310, 12'd0,    12'd205,
      12'd1884, 12'd2948, 12'd2375, 12'd1556, 12'd1802,
      12'd1720, 12'd1269, 12'd1147, 12'd2375, 12'd1843,
      12'd2129, 12'd3522, 12'd2252, 12'd1065, 12'd737,
      12'd573,  12'd655,  12'd983,  12'd1802, 12'd1433,
      12'd1392, 12'd901,  12'd1147, 12'd1720, 12'd2948,
      12'd3440, 12'd2785, 12'd901,  12'd1474, 12'd1147,
      12'd1474, 12'd1392, 12'd1474, 12'd1720, 12'd1843,
      12'd1966, 12'd1720, 12'd3358, 12'd1392, 12'd983
   };

   // Quotient by a constant through its reciprocal, with one correction step.
   function automatic logic [31:0] recip_div(input logic [31:0] x, input logic [31:0] m,
                                             input logic [5:0] k, input logic [31:0] d);
      logic [63:0] p;
      logic [31:0] q;
      logic [31:0] r;
      p = {32'd0, x} * {32'd0, m};
      q = 32'(p >> k);
      r = x - 32'(q * d);
      if (r >= d) begin
         q = q + 32'd1;
      end
      return q;
   endfunction

   function automatic frac_type sat_one(input logic [31:0] v);
      return (v > {20'd0, ONE}) ? ONE : v[FRAC_W-1:0];
   endfunction

endpackage

/* rtl/adaptive_nearest_centroid_classifier.sv */
// A classify request computes the ten features, walks the centroid RAM, takes two square roots
// of one load and 13 steps each, computes the confidence and loads the result. A learn request
// computes the features and the rate, then reads, blends and writes back each element; quiet,
// restore, refused and unused-mode requests go straight to the result load.
// One request at a time; req_stall drops once the result is loaded, and a stalled earlier
// result keeps the block waiting to load the new one.
// Reset restores the default centroids at once (row valid bits), clears weights and loads
// the register defaults; no clearing pass is needed.
module adaptive_nearest_centroid_classifier
   import ancc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [2:0]  req_style,
   input  logic [11:0] req_learn_confidence,
   input  logic [11:0] req_rms,
   input  logic [11:0] req_peak,
   input  logic [59:0] req_bands,
   input  logic [11:0] req_spectral_centroid,
   input  logic [11:0] req_stereo_width,
   input  logic [11:0] req_tempo,
   input  logic [11:0] req_onset,
   input  logic [11:0] req_beat_confidence,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_class_out,
   output logic [11:0] rsp_confidence_out,
   output logic [11:0] rsp_class_weight,
   output logic        rsp_updated,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_data
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FEAT,
      ST_WALK,
      ST_SQ_LOAD,
      ST_SQ_ITER,
      ST_CONF_NUM,
      ST_CONF_DIV,
      ST_RATE,
      ST_L_RD,
      ST_L_MUL,
      ST_L_WR,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   frac_type sil_rms_ff, sil_rms_in;
   frac_type sil_peak_ff, sil_peak_in;
   frac_type min_conf_ff, min_conf_in;
   frac_type min_rms_ff, min_rms_in;

   // Captured request fields.
   logic [2:0]  style_ff, style_in;
   frac_type    lconf_ff, lconf_in;
   frac_type    rms_ff, rms_in;
   logic [59:0] bands_ff, bands_in;
   frac_type    sc_ff, sc_in;
   frac_type    sw_ff, sw_in;
   frac_type    tempo_ff, tempo_in;
   frac_type    onset_ff, onset_in;
   frac_type    bc_ff, bc_in;
   logic        learn_ff, learn_in;

   frac_type feat_ff [NUM_FEAT];
   frac_type feat_in [NUM_FEAT];

   // Walk counters and the read pipeline stage.
   logic [2:0] ws_ff, ws_in;
   logic [3:0] wi_ff, wi_in;
   logic       issue_done_ff, issue_done_in;
   logic       pv_ff, pv_in;
   logic [2:0] ps_ff, ps_in;
   logic [3:0] pi_ff, pi_in;
   logic       prv_ff, prv_in;
   frac_type   pdef_ff, pdef_in;

   logic [27:0] acc_ff, acc_in;
   logic [27:0] best_sum_ff, best_sum_in;
   logic [27:0] second_sum_ff, second_sum_in;
   logic        have_best_ff, have_best_in;
   logic        have_second_ff, have_second_in;

   logic [2:0] cls_ff, cls_in;
   frac_type   conf_ff, conf_in;
   logic       upd_ff, upd_in;

   // Shared square root unit.
   logic        sq_sel_ff, sq_sel_in;
   logic [25:0] sq_rem_ff, sq_rem_in;
   logic [25:0] sq_root_ff, sq_root_in;
   logic [25:0] sq_bit_ff, sq_bit_in;
   logic [3:0]  sq_cnt_ff, sq_cnt_in;
   frac_type    best_d_ff, best_d_in;
   frac_type    second_d_ff, second_d_in;

   logic [20:0] num_ff, num_in;
   logic [7:0]  r_ff, r_in;
   logic [24:0] prod_ff, prod_in;

   logic [NUM_STYLES-1:0] row_valid_ff, row_valid_in;
   frac_type weights_ff [NUM_STYLES];
   frac_type weights_in [NUM_STYLES];

   logic     rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_class_ff, rsp_class_in;
   frac_type rsp_conf_ff, rsp_conf_in;
   frac_type rsp_weight_ff, rsp_weight_in;
   logic     rsp_upd_ff, rsp_upd_in;

   // Centroid RAM port.
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   frac_type          ram_wr_data;
   frac_type          ram_q;

   ancc_ram #(
      .WIDTH (FRAC_W),
      .DEPTH (NUM_ELEM)
   ) u_centroids (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_q)
   );

   assign req_stall          = (state_ff != ST_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_class_out      = rsp_class_ff;
   assign rsp_confidence_out = rsp_conf_ff;
   assign rsp_class_weight   = rsp_weight_ff;
   assign rsp_updated        = rsp_upd_ff;

   logic [ADDR_W-1:0] walk_addr;
   assign walk_addr = ADDR_W'(ws_ff) * ADDR_W'(NUM_FEAT) + ADDR_W'(wi_ff);

   // The feature addressed by the element counter, one per cycle.
   frac_type feat_new;
   always_comb begin
      unique case (wi_ff)
         4'd0: feat_new = sat_one(recip_div({20'd0, rms_ff} * 32'd17 + 32'd5,
                                            RECIP_10_SMALL, 6'd20, 32'd10));
         4'd1: feat_new = bands_ff[11:0];
         4'd2: feat_new = bands_ff[23:12];
         4'd3: feat_new = bands_ff[35:24];
         4'd4: feat_new = bands_ff[47:36];
         4'd5: feat_new = bands_ff[59:48];
         4'd6: feat_new = sc_ff;
         4'd7: feat_new = sw_ff;
         4'd8: begin
            if (tempo_ff > 12'd560) begin
               feat_new = sat_one(recip_div(({20'd0, tempo_ff} - 32'd560) * {20'd0, ONE}
                                            + 32'd560, RECIP_1120, 6'd32, 32'd1120));
            end else begin
               feat_new = '0;
            end
         end
         4'd9: feat_new = sat_one({18'd0, onset_ff, 2'b00}
                                  + recip_div({20'd0, bc_ff} * 32'd35 + 32'd50,
                                              RECIP_100, 6'd28, 32'd100));
         default: feat_new = '0;
      endcase
   end

   // Distance accumulation for the element coming out of the RAM.
   frac_type           walk_c;
   logic signed [12:0] walk_d;
   logic signed [25:0] walk_sq;
   logic [27:0]        row_sum;
   assign walk_c  = prv_ff ? ram_q : pdef_ff;
   assign walk_d  = $signed({1'b0, feat_ff[pi_ff]}) - $signed({1'b0, walk_c});
   assign walk_sq = walk_d * walk_d;
   assign row_sum = acc_ff + {2'b00, walk_sq};

   // One square root step.
   logic [26:0] sq_trial;
   logic [25:0] sq_root_step;
   assign sq_trial = {1'b0, sq_root_ff} + {1'b0, sq_bit_ff};

   frac_type margin;
   assign margin = (second_d_ff >= best_d_ff) ? (second_d_ff - best_d_ff) : '0;

   logic quiet;
   logic learn_ok;
   assign quiet    = (req_rms < sil_rms_ff) && (req_peak < sil_peak_ff);
   assign learn_ok = (req_style != 3'd0) && (req_style < 3'(NUM_STYLES))
                     && (req_learn_confidence >= min_conf_ff) && (req_rms >= min_rms_ff);

   always_comb begin
      state_in       = state_ff;
      sil_rms_in     = sil_rms_ff;
      sil_peak_in    = sil_peak_ff;
      min_conf_in    = min_conf_ff;
      min_rms_in     = min_rms_ff;
      style_in       = style_ff;
      lconf_in       = lconf_ff;
      rms_in         = rms_ff;
      bands_in       = bands_ff;
      sc_in          = sc_ff;
      sw_in          = sw_ff;
      tempo_in       = tempo_ff;
      onset_in       = onset_ff;
      bc_in          = bc_ff;
      learn_in       = learn_ff;
      feat_in        = feat_ff;
      ws_in          = ws_ff;
      wi_in          = wi_ff;
      issue_done_in  = issue_done_ff;
      pv_in          = 1'b0;
      ps_in          = ps_ff;
      pi_in          = pi_ff;
      prv_in         = prv_ff;
      pdef_in        = pdef_ff;
      acc_in         = acc_ff;
      best_sum_in    = best_sum_ff;
      second_sum_in  = second_sum_ff;
      have_best_in   = have_best_ff;
      have_second_in = have_second_ff;
      cls_in         = cls_ff;
      conf_in        = conf_ff;
      upd_in         = upd_ff;
      sq_sel_in      = sq_sel_ff;
      sq_rem_in      = sq_rem_ff;
      sq_root_in     = sq_root_ff;
      sq_bit_in      = sq_bit_ff;
      sq_cnt_in      = sq_cnt_ff;
      sq_root_step   = sq_root_ff >> 1;
      best_d_in      = best_d_ff;
      second_d_in    = second_d_ff;
      num_in         = num_ff;
      r_in           = r_ff;
      prod_in        = prod_ff;
      row_valid_in   = row_valid_ff;
      weights_in     = weights_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_class_in   = rsp_class_ff;
      rsp_conf_in    = rsp_conf_ff;
      rsp_weight_in  = rsp_weight_ff;
      rsp_upd_in     = rsp_upd_ff;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = walk_addr;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = walk_addr;
      ram_wr_data    = sat_one(recip_div({7'd0, prod_ff}, RECIP_ONE, 6'd32, {20'd0, ONE}));

      // Register writes are to be made only while the block is idle; the block itself does not enforce it.
      if (csr_valid) begin
         unique case (csr_type'(csr_index))
            CSR_SILENCE_RMS:  sil_rms_in  = csr_data;
            CSR_SILENCE_PEAK: sil_peak_in = csr_data;
            CSR_LEARN_CONF:   min_conf_in = csr_data;
            CSR_LEARN_RMS:    min_rms_in  = csr_data;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               style_in = req_style;
               lconf_in = req_learn_confidence;
               rms_in   = req_rms;
               bands_in = req_bands;
               sc_in    = req_spectral_centroid;
               sw_in    = req_stereo_width;
               tempo_in = req_tempo;
               onset_in = req_onset;
               bc_in    = req_beat_confidence;
               wi_in    = '0;
               cls_in   = req_style;
               conf_in  = '0;
               upd_in   = 1'b0;
               learn_in = 1'b0;
               state_in = ST_DONE;
               unique case (mode_type'(req_mode))
                  MODE_CLASSIFY: begin
                     if (quiet) begin
                        cls_in  = '0;
                        conf_in = ONE;
                     end else begin
                        state_in = ST_FEAT;
                     end
                  end
                  MODE_LEARN: begin
                     if (learn_ok) begin
                        learn_in = 1'b1;
                        state_in = ST_FEAT;
                     end
                  end
                  MODE_RESTORE: begin
                     row_valid_in = '0;
                     for (int s = 0; s < NUM_STYLES; s++) begin
                        weights_in[s] = '0;
                     end
                  end
                  MODE_UNUSED: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_FEAT: begin
            feat_in[wi_ff] = feat_new;
            wi_in          = wi_ff + 4'd1;
            if (wi_ff == 4'(NUM_FEAT - 1)) begin
               wi_in          = '0;
               ws_in          = learn_ff ? style_ff : '0;
               issue_done_in  = 1'b0;
               acc_in         = '0;
               have_best_in   = 1'b0;
               have_second_in = 1'b0;
               cls_in         = learn_ff ? style_ff : '0;
               state_in       = learn_ff ? ST_RATE : ST_WALK;
            end
         end

         ST_WALK: begin
            if (!issue_done_ff) begin
               ram_rd_en = 1'b1;
               pv_in     = 1'b1;
               ps_in     = ws_ff;
               pi_in     = wi_ff;
               prv_in    = row_valid_ff[ws_ff];
               pdef_in   = DEFAULT_CENTROID[walk_addr];
               if (wi_ff == 4'(NUM_FEAT - 1)) begin
                  wi_in = '0;
                  ws_in = ws_ff + 3'd1;
                  if (ws_ff == 3'(NUM_STYLES - 1)) begin
                     issue_done_in = 1'b1;
                  end
               end else begin
                  wi_in = wi_ff + 4'd1;
               end
            end
            if (pv_ff) begin
               acc_in = row_sum;
               if (pi_ff == 4'(NUM_FEAT - 1)) begin
                  acc_in = '0;
                  if (!have_best_ff || row_sum < best_sum_ff) begin
                     if (have_best_ff) begin
                        second_sum_in  = best_sum_ff;
                        have_second_in = 1'b1;
                     end
                     best_sum_in  = row_sum;
                     cls_in       = ps_ff;
                     have_best_in = 1'b1;
                  end else if (!have_second_ff || row_sum < second_sum_ff) begin
                     second_sum_in  = row_sum;
                     have_second_in = 1'b1;
                  end
                  if (ps_ff == 3'(NUM_STYLES - 1)) begin
                     sq_sel_in = 1'b0;
                     state_in  = ST_SQ_LOAD;
                  end
               end
            end
         end

         ST_SQ_LOAD: begin
            sq_rem_in  = 26'(recip_div({4'd0, sq_sel_ff ? second_sum_ff : best_sum_ff},
                                       RECIP_10_WIDE, 6'd32, 32'd10));
            sq_root_in = '0;
            sq_bit_in  = 26'd1 << 24;
            sq_cnt_in  = '0;
            state_in   = ST_SQ_ITER;
         end

         ST_SQ_ITER: begin
            if ({1'b0, sq_rem_ff} >= sq_trial) begin
               sq_rem_in    = sq_rem_ff - sq_trial[25:0];
               sq_root_step = (sq_root_ff >> 1) + sq_bit_ff;
            end
            sq_root_in = sq_root_step;
            sq_bit_in  = sq_bit_ff >> 2;
            sq_cnt_in  = sq_cnt_ff + 4'd1;
            if (sq_cnt_ff == 4'd12) begin
               if (sq_sel_ff) begin
                  second_d_in = sat_one({6'd0, sq_root_step});
                  state_in    = ST_CONF_NUM;
               end else begin
                  best_d_in = sat_one({6'd0, sq_root_step});
                  sq_sel_in = 1'b1;
                  state_in  = ST_SQ_LOAD;
               end
            end
         end

         ST_CONF_NUM: begin
            num_in   = 21'(32'd20 * {20'd0, ONE} + 32'd240 * {20'd0, margin}
                           + 32'd18 * {20'd0, ONE - best_d_ff} + 32'd50);
            state_in = ST_CONF_DIV;
         end

         ST_CONF_DIV: begin
            conf_in  = sat_one(recip_div({11'd0, num_ff}, RECIP_100, 6'd28, 32'd100));
            state_in = ST_DONE;
         end

         ST_RATE: begin
            r_in     = 8'(recip_div(32'd15 * {20'd0, ONE} + 32'd25 * {20'd0, lconf_ff}
                                    + 32'd500, RECIP_1000, 6'd28, 32'd1000));
            state_in = ST_L_RD;
         end

         ST_L_RD: begin
            ram_rd_en = 1'b1;
            prv_in    = row_valid_ff[ws_ff];
            pdef_in   = DEFAULT_CENTROID[walk_addr];
            state_in  = ST_L_MUL;
         end

         ST_L_MUL: begin
            prod_in  = 25'({20'd0, walk_c} * {20'd0, ONE - {4'd0, r_ff}}
                           + {20'd0, feat_ff[wi_ff]} * {24'd0, r_ff}
                           + {20'd0, ONE >> 1});
            state_in = ST_L_WR;
         end

         ST_L_WR: begin
            ram_wr_en = 1'b1;
            wi_in     = wi_ff + 4'd1;
            state_in  = ST_L_RD;
            if (wi_ff == 4'(NUM_FEAT - 1)) begin
               row_valid_in[ws_ff] = 1'b1;
               weights_in[ws_ff]   = sat_one({20'd0, weights_ff[ws_ff]} + {24'd0, r_ff});
               upd_in              = 1'b1;
               state_in            = ST_DONE;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_class_in  = cls_ff;
               rsp_conf_in   = conf_ff;
               rsp_weight_in = (cls_ff < 3'(NUM_STYLES)) ? weights_ff[cls_ff] : '0;
               rsp_upd_in    = upd_ff;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sil_rms_ff   <= 12'd25;
         sil_peak_ff  <= 12'd82;
         min_conf_ff  <= 12'd1147;
         min_rms_ff   <= 12'd41;
         pv_ff        <= 1'b0;
         row_valid_ff <= '0;
         for (int s = 0; s < NUM_STYLES; s++) begin
            weights_ff[s] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sil_rms_ff   <= sil_rms_in;
         sil_peak_ff  <= sil_peak_in;
         min_conf_ff  <= min_conf_in;
         min_rms_ff   <= min_rms_in;
         pv_ff        <= pv_in;
         row_valid_ff <= row_valid_in;
         weights_ff   <= weights_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers carry no reset.
   always_ff @(posedge clock) begin
      style_ff       <= style_in;
      lconf_ff       <= lconf_in;
      rms_ff         <= rms_in;
      bands_ff       <= bands_in;
      sc_ff          <= sc_in;
      sw_ff          <= sw_in;
      tempo_ff       <= tempo_in;
      onset_ff       <= onset_in;
      bc_ff          <= bc_in;
      learn_ff       <= learn_in;
      feat_ff        <= feat_in;
      ws_ff          <= ws_in;
      wi_ff          <= wi_in;
      issue_done_ff  <= issue_done_in;
      ps_ff          <= ps_in;
      pi_ff          <= pi_in;
      prv_ff         <= prv_in;
      pdef_ff        <= pdef_in;
      acc_ff         <= acc_in;
      best_sum_ff    <= best_sum_in;
      second_sum_ff  <= second_sum_in;
      have_best_ff   <= have_best_in;
      have_second_ff <= have_second_in;
      cls_ff         <= cls_in;
      conf_ff        <= conf_in;
      upd_ff         <= upd_in;
      sq_sel_ff      <= sq_sel_in;
      sq_rem_ff      <= sq_rem_in;
      sq_root_ff     <= sq_root_in;
      sq_bit_ff      <= sq_bit_in;
      sq_cnt_ff      <= sq_cnt_in;
      best_d_ff      <= best_d_in;
      second_d_ff    <= second_d_in;
      num_ff         <= num_in;
      r_ff           <= r_in;
      prod_ff        <= prod_in;
      rsp_class_ff   <= rsp_class_in;
      rsp_conf_ff    <= rsp_conf_in;
      rsp_weight_ff  <= rsp_weight_in;
      rsp_upd_ff     <= rsp_upd_in;
   end

   // A learn update always reports zero confidence.
   a_upd_no_conf: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_upd_ff) |-> (rsp_conf_ff == '0))
      else $error("learn result carries a confidence");

   // A learn update always leaves a nonzero weight for its style.
   a_upd_weight: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_upd_ff) |-> (rsp_weight_ff != '0))
      else $error("learn result with zero weight");

   // Writing the last element of a learned row marks the row as stored.
   a_row_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_L_WR && wi_ff == 4'(NUM_FEAT - 1)) |=> row_valid_ff[$past(ws_ff)])
      else $error("learned row not marked valid");

   // The square root never runs past its last step.
   a_sq_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQ_ITER) |-> (sq_cnt_ff <= 4'd12))
      else $error("square root step count overrun");

endmodule

/* rtl/ancc_ram.sv */
module ancc_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 60,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* tb/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ancc_pkg::*;

   // Five random phases follow the directed table. Each phase gets its own
   // register setting; the idling patterns alternate, and the last runs without any idling.
   localparam int PHASE_ITEMS = 230;
   localparam int NUM_PHASES  = 5;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int DRAIN_WAIT  = 120;

   typedef struct {
      mode_type    mode;
      logic [2:0]  style;
      logic [11:0] lconf;
      logic [11:0] rms;
      logic [11:0] peak;
      logic [59:0] bands;
      logic [11:0] spec;
      logic [11:0] width;
      logic [11:0] tempo;
      logic [11:0] onset;
      logic [11:0] beat;
   } frame_type;

   typedef struct {
      logic [2:0]  cls;
      logic [11:0] conf;
      logic [11:0] weight;
      logic        upd;
   } answer_type;

   typedef struct {
      frame_type  f;
      bit         typed;
      answer_type a;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_mode = 2'd0;
   logic [2:0]  req_style = 3'd0;
   logic [11:0] req_learn_confidence = 12'd0;
   logic [11:0] req_rms = 12'd0;
   logic [11:0] req_peak = 12'd0;
   logic [59:0] req_bands = 60'd0;
   logic [11:0] req_spectral_centroid = 12'd0;
   logic [11:0] req_stereo_width = 12'd0;
   logic [11:0] req_tempo = 12'd0;
   logic [11:0] req_onset = 12'd0;
   logic [11:0] req_beat_confidence = 12'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_class_out;
   logic [11:0] rsp_confidence_out;
   logic [11:0] rsp_class_weight;
   logic        rsp_updated;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = 2'd0;
   logic [11:0] csr_data = 12'd0;

   always #5 clock = ~clock;

   adaptive_nearest_centroid_classifier dut (.*);

   // Our own copy of the block's state: centroids, weights and the four registers.
   int unsigned centroids [NUM_STYLES][NUM_FEAT];
   int unsigned weights   [NUM_STYLES];
   int unsigned limits    [4];

   answer_type pending_answers [$];
   row_type    rows [$];
   int         errors = 0;
   int         cycles = 0;
   int         send_gap_pct = 0;
   int         stall_pct = 0;

   // Default centroids in hundredths of full scale, one row per style.
   const int unsigned default_pct [NUM_STYLES][NUM_FEAT] = '{
      '{ 0,  0,  0,  0,  0,  0,  0,  0,  0,  0},
      '{13, 16, 24, 32, 24, 22, 28, 32,  0,  5},
      '{46, 72, 58, 38, 44, 42, 31, 28, 58, 45},
      '{52, 86, 55, 26, 18, 14, 16, 24, 44, 35},
      '{34, 22, 28, 42, 72, 84, 68, 22, 36, 28},
      '{36, 34, 36, 42, 45, 48, 42, 82, 34, 24}
   };

   function automatic int unsigned clamp_full(longint unsigned v);
      return (v > ONE) ? int'(ONE) : int'(v);
   endfunction

   function automatic void restore_centroids();
      foreach (centroids[s, i]) centroids[s][i] = (default_pct[s][i] * ONE + 50) / 100;
      foreach (weights[s]) weights[s] = 0;
   endfunction

   function automatic int unsigned int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return int'(root);
   endfunction

   // Maps a metrics frame to its ten clamped feature fractions.
   function automatic void frame_features(frame_type f, output int unsigned feat [NUM_FEAT]);
      longint unsigned tempo;
      tempo = f.tempo;
      feat[0] = clamp_full((longint'(f.rms) * 17 + 5) / 10);
      for (int b = 0; b < 5; b++) feat[1 + b] = f.bands[12*b +: 12];
      feat[6] = f.spec;
      feat[7] = f.width;
      feat[8] = (tempo > 560) ? clamp_full(((tempo - 560) * ONE + 560) / 1120) : 0;
      feat[9] = clamp_full(4 * longint'(f.onset) + (longint'(f.beat) * 35 + 50) / 100);
   endfunction

   // Computes the answer for one accepted request and advances the state copy.
   function automatic answer_type classify_or_learn(frame_type f);
      answer_type      a;
      int unsigned     feat [NUM_FEAT];
      longint unsigned sum, best_sum, second_sum;
      bit              have_best, have_second;
      int unsigned     best, second, margin, rate;
      longint          d;
      a.cls = f.style;
      a.conf = 0;
      a.upd = 1'b0;
      if (f.mode == MODE_CLASSIFY) begin
         if (f.rms < limits[CSR_SILENCE_RMS] && f.peak < limits[CSR_SILENCE_PEAK]) begin
            // A quiet frame is silence with full confidence, no search at all.
            a.cls = 3'd0;
            a.conf = ONE;
         end else begin
            frame_features(f, feat);
            have_best = 0;
            have_second = 0;
            best_sum = 0;
            second_sum = 0;
            a.cls = 3'd0;
            for (int s = 0; s < NUM_STYLES; s++) begin
               sum = 0;
               for (int i = 0; i < NUM_FEAT; i++) begin
                  d = longint'(feat[i]) - longint'(centroids[s][i]);
                  sum += longint'(d * d);
               end
               // Strict compare: the first style wins a tie.
               if (!have_best || sum < best_sum) begin
                  if (have_best) begin
                     second_sum = best_sum;
                     have_second = 1;
                  end
                  best_sum = sum;
                  a.cls = 3'(s);
                  have_best = 1;
               end else if (!have_second || sum < second_sum) begin
                  second_sum = sum;
                  have_second = 1;
               end
            end
            best = clamp_full(int_sqrt(best_sum / NUM_FEAT));
            second = clamp_full(int_sqrt(second_sum / NUM_FEAT));
            margin = (second >= best) ? second - best : 0;
            a.conf = 12'(clamp_full((20 * longint'(ONE) + 240 * longint'(margin)
                                     + 18 * longint'(ONE - best) + 50) / 100));
         end
      end else if (f.mode == MODE_LEARN) begin
         if (f.style != 0 && f.style < NUM_STYLES && f.lconf >= limits[CSR_LEARN_CONF]
             && f.rms >= limits[CSR_LEARN_RMS]) begin
            rate = (15 * ONE + 25 * f.lconf + 500) / 1000;
            frame_features(f, feat);
            for (int i = 0; i < NUM_FEAT; i++) begin
               centroids[f.style][i] = clamp_full((longint'(centroids[f.style][i])
                  * (ONE - rate) + longint'(feat[i]) * rate + ONE / 2) / ONE);
            end
            weights[f.style] = clamp_full(longint'(weights[f.style]) + rate);
            a.upd = 1'b1;
         end
      end else if (f.mode == MODE_RESTORE) begin
         restore_centroids();
      end
      a.weight = (a.cls < NUM_STYLES) ? 12'(weights[a.cls]) : 12'd0;
      return a;
   endfunction

   function automatic frame_type make_frame(mode_type m, int style, int lconf, int rms,
                                            int peak, logic [59:0] bands, int spec,
                                            int width, int tempo, int onset, int beat);
      frame_type f;
      f.mode = m;
      f.style = 3'(style);
      f.lconf = 12'(lconf);
      f.rms = 12'(rms);
      f.peak = 12'(peak);
      f.bands = bands;
      f.spec = 12'(spec);
      f.width = 12'(width);
      f.tempo = 12'(tempo);
      f.onset = 12'(onset);
      f.beat = 12'(beat);
      return f;
   endfunction

   // Appends one row to the directed table.
   function automatic void add_row(frame_type f, bit typed, answer_type a);
      row_type r;
      r.f = f;
      r.typed = typed;
      r.a = a;
      rows = {rows, r};
   endfunction

   function automatic int unsigned jitter(int unsigned v);
      int t;
      t = int'(v) + int'($urandom_range(400)) - 200;
      return (t < 0) ? 0 : (t > int'(ONE)) ? ONE : t;
   endfunction

   // Random request. Most are frames built around a stored centroid so that
   // nearest and second-nearest distances are close and learning is exercised;
   // the rest are raw random fields and quiet frames.
   function automatic frame_type random_frame();
      frame_type   f;
      int unsigned pick, s;
      int unsigned t [NUM_FEAT];
      pick = $urandom_range(99);
      f = make_frame(MODE_CLASSIFY, $urandom_range(7), $urandom_range(4095),
                     $urandom_range(4095), $urandom_range(4095),
                     60'({$urandom, $urandom}), $urandom_range(4095), $urandom_range(4095),
                     $urandom_range(4095), $urandom_range(4095), $urandom_range(4095));
      if (pick < 50) f.mode = MODE_CLASSIFY;
      else if (pick < 90) f.mode = MODE_LEARN;
      else if (pick < 95) f.mode = MODE_RESTORE;
      else f.mode = MODE_UNUSED;
      if ($urandom_range(99) < 65) begin
         s = $urandom_range(NUM_STYLES - 1);
         foreach (t[i]) t[i] = jitter(centroids[s][i]);
         f.rms = 12'(t[0] * 10 / 17);
         for (int b = 0; b < 5; b++) f.bands[12*b +: 12] = 12'(t[1 + b]);
         f.spec = 12'(t[6]);
         f.width = 12'(t[7]);
         f.tempo = (t[8] == 0) ? 12'($urandom_range(560)) : 12'(560 + t[8] * 1120 / ONE);
         f.onset = 12'(t[9] / 4);
         f.beat = 12'($urandom_range(40));
         if (f.mode == MODE_LEARN && $urandom_range(99) < 80) begin
            f.style = 3'($urandom_range(NUM_STYLES - 1, 1));
            f.lconf = 12'($urandom_range(ONE, limits[CSR_LEARN_CONF]));
            if (f.rms < limits[CSR_LEARN_RMS])
               f.rms = 12'($urandom_range(ONE, limits[CSR_LEARN_RMS]));
         end
      end
      if ($urandom_range(99) < 8) begin
         f.rms = 12'($urandom_range(limits[CSR_SILENCE_RMS] + 2));
         f.peak = 12'($urandom_range(limits[CSR_SILENCE_PEAK] + 2));
      end
      return f;
   endfunction

   task automatic report(string what, int got, int want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
      errors++;
   endtask

   // Holds one request on the input until it is accepted, then records what it
   // must produce. Called at a rising edge; returns at the accepting edge.
   task automatic send_frame(frame_type f, bit typed, answer_type typed_answer);
      answer_type predicted;
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= f.mode;
      req_style <= f.style;
      req_learn_confidence <= f.lconf;
      req_rms <= f.rms;
      req_peak <= f.peak;
      req_bands <= f.bands;
      req_spectral_centroid <= f.spec;
      req_stereo_width <= f.width;
      req_tempo <= f.tempo;
      req_onset <= f.onset;
      req_beat_confidence <= f.beat;
      do @(posedge clock); while (req_stall);
      predicted = classify_or_learn(f);
      if (typed) predicted = typed_answer;
      pending_answers = {pending_answers, predicted};
   endtask

   // The sender holds off until every pending answer is back, so the block is idle.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(csr_type idx, int unsigned value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= 12'(value);
      do @(posedge clock); while (!csr_ready);
      limits[idx] = value;
   endtask

   task automatic write_all(int unsigned r, int unsigned p, int unsigned c, int unsigned m);
      write_register(CSR_SILENCE_RMS, r);
      write_register(CSR_SILENCE_PEAK, p);
      write_register(CSR_LEARN_CONF, c);
      write_register(CSR_LEARN_RMS, m);
      csr_valid <= 1'b0;
   endtask

   // Responses are checked at each rising edge where one is taken.
   always @(posedge clock) begin
      answer_type want;
      rsp_stall <= ($urandom_range(99) < stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            report("unexpected response, class", rsp_class_out, -1);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_class_out !== want.cls) report("class_out", rsp_class_out, want.cls);
            if (rsp_confidence_out !== want.conf)
               report("confidence_out", rsp_confidence_out, want.conf);
            if (rsp_class_weight !== want.weight)
               report("class_weight", rsp_class_weight, want.weight);
            if (rsp_updated !== want.upd) report("updated", rsp_updated, want.upd);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   initial begin
      answer_type  none;
      logic [59:0] all_ones;
      int          waited;
      none = '{cls: 3'd0, conf: 12'd0, weight: 12'd0, upd: 1'b0};
      all_ones = '1;
      restore_centroids();
      limits[CSR_SILENCE_RMS] = 25;
      limits[CSR_SILENCE_PEAK] = 82;
      limits[CSR_LEARN_CONF] = 1147;
      limits[CSR_LEARN_RMS] = 41;

      // Directed table. Rows with a typed answer can be read off directly:
      // quiet frames, refused learns, the unused mode and restore.
      add_row(make_frame(MODE_CLASSIFY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
              '{3'd0, ONE, 12'd0, 1'b0});
      add_row(make_frame(MODE_CLASSIFY, 7, 4095, 4095, 4095, all_ones, 4095, 4095,
                         4095, 4095, 4095), 0, none);
      add_row(make_frame(MODE_CLASSIFY, 0, 0, 4095, 0, 0, 0, 0, 0, 0, 0), 0, none);
      add_row(make_frame(MODE_CLASSIFY, 0, 0, 25, 0, 0, 0, 0, 0, 0, 0), 0, none);
      add_row(make_frame(MODE_CLASSIFY, 0, 0, 0, 82, 0, 0, 0, 0, 0, 0), 0, none);
      add_row(make_frame(MODE_CLASSIFY, 0, 0, 24, 81, 0, 0, 0, 0, 0, 0), 1,
              '{3'd0, ONE, 12'd0, 1'b0});
      add_row(make_frame(MODE_CLASSIFY, 0, 0, 900, 0, 60'h555_AAA_555_AAA_555,
                         2730, 1365, 561, 1000, 2000), 0, none);
      add_row(make_frame(MODE_CLASSIFY, 0, 0, 900, 900, 60'hAAA_555_AAA_555_AAA,
                         1365, 2730, 560, 0, 4095), 0, none);
      add_row(make_frame(MODE_LEARN, 0, 4095, 4095, 0, 0, 0, 0, 0, 0, 0), 1, none);
      add_row(make_frame(MODE_LEARN, 6, 4095, 4095, 0, 0, 0, 0, 0, 0, 0), 1,
              '{3'd6, 12'd0, 12'd0, 1'b0});
      add_row(make_frame(MODE_LEARN, 7, 4095, 4095, 0, 0, 0, 0, 0, 0, 0), 1,
              '{3'd7, 12'd0, 12'd0, 1'b0});
      add_row(make_frame(MODE_LEARN, 2, 1146, 4095, 0, 0, 0, 0, 0, 0, 0), 1,
              '{3'd2, 12'd0, 12'd0, 1'b0});
      add_row(make_frame(MODE_LEARN, 2, 4095, 40, 0, 0, 0, 0, 0, 0, 0), 1,
              '{3'd2, 12'd0, 12'd0, 1'b0});
      add_row(make_frame(MODE_LEARN, 2, 1147, 41, 0, all_ones, 4095, 0, 4095,
                         4095, 0), 0, none);
      add_row(make_frame(MODE_LEARN, 5, 4095, 4095, 4095, all_ones, 4095, 4095,
                         4095, 4095, 4095), 0, none);
      add_row(make_frame(MODE_LEARN, 5, 4095, 4095, 4095, all_ones, 4095, 4095,
                         4095, 4095, 4095), 0, none);
      add_row(make_frame(MODE_CLASSIFY, 5, 0, 4095, 4095, all_ones, 4095, 4095,
                         4095, 4095, 4095), 0, none);
      add_row(make_frame(MODE_UNUSED, 3, 4095, 4095, 4095, 0, 0, 0, 0, 0, 0), 1,
              '{3'd3, 12'd0, 12'd0, 1'b0});
      add_row(make_frame(MODE_RESTORE, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
              '{3'd5, 12'd0, 12'd0, 1'b0});
      add_row(make_frame(MODE_CLASSIFY, 5, 0, 4095, 4095, all_ones, 4095, 4095,
                         4095, 4095, 4095), 0, none);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) send_frame(rows[i].f, rows[i].typed, rows[i].a);
      drain();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: begin
               write_all(25, 82, 1147, 41);
               send_gap_pct = 30;
               stall_pct = 77;
            end
            1: begin
               write_all(0, 0, 0, 0);
               send_gap_pct = 77;
               stall_pct = 30;
            end
            2: begin
               write_all(4095, 4095, 4095, 4095);
               send_gap_pct = 30;
               stall_pct = 77;
            end
            3: begin
               write_all(300, 700, 600, 150);
               send_gap_pct = 77;
               stall_pct = 30;
            end
            default: begin
               write_all($urandom_range(200), $urandom_range(400), $urandom_range(3000),
                         $urandom_range(300));
               send_gap_pct = 0;
               stall_pct = 0;
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) send_frame(random_frame(), 0, none);
         drain();
      end

      waited = 0;
      while (pending_answers.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0 && pending_answers.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end
endmodule

/* adaptive_nearest_centroid_classifier.f */
rtl/ancc_pkg.sv
rtl/ancc_ram.sv
rtl/adaptive_nearest_centroid_classifier.sv
tb/tb_top.sv
